[sv/loq_pkg.sv]
// ----------------------------------------------------------------------------
// loq_pkg
// shared types, widths and codes of the level outlier qualifier
// ----------------------------------------------------------------------------
package loq_pkg;

   localparam int LEVEL_W = 16;
   localparam int Q_W     = 20;   // unsigned Q16.4 quantities
   localparam int FRAC_W  = 4;
   localparam int COUNT_W = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam int COUNT_MAX_DEFAULT = 255;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEVIATION_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_TOLERANCE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_COUNT     = 2'd2;

   localparam logic [Q_W-1:0]     DEVIATION_LIMIT_RST = 20'd160;
   localparam logic [Q_W-1:0]     MEAN_TOLERANCE_RST  = 20'd320;
   localparam logic [COUNT_W-1:0] ALARM_COUNT_RST     = 8'd5;

   typedef enum logic {
      OP_EVALUATE = 1'b0,
      OP_CLEAR    = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      VERDICT_OK         = 2'd0,
      VERDICT_ALARM      = 2'd1,
      VERDICT_HEAD_RESET = 2'd2
   } verdict_type;

   typedef struct packed {
      op_type              operation;
      logic [LEVEL_W-1:0]  level;
      logic [Q_W-1:0]      mean_level;
      logic [Q_W-1:0]      deviation;
   } req_item_type;

   typedef struct packed {
      verdict_type         verdict;
      logic                outlier_flag;
      logic [COUNT_W-1:0]  outlier_count;
      logic [LEVEL_W-1:0]  bad_value;
      logic [LEVEL_W-1:0]  good_value;
   } rsp_item_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic [LEVEL_W-1:0]  bad;
      logic [LEVEL_W-1:0]  good;
   } state_type;

   typedef struct packed {
      logic [Q_W-1:0]      deviation_limit;
      logic [Q_W-1:0]      mean_tolerance;
      logic [COUNT_W-1:0]  alarm_count;
   } cfg_type;

endpackage

[sv/loq_if.sv]
// ----------------------------------------------------------------------------
// loq_if
// valid/ready channels for report items and result items
// ----------------------------------------------------------------------------
interface loq_req_if
   import loq_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                operation;
   logic [LEVEL_W-1:0]  level;
   logic [Q_W-1:0]      mean_level;
   logic [Q_W-1:0]      deviation;

   modport source (output valid, output operation, output level,
                   output mean_level, output deviation, input ready);
   modport sink   (input valid, input operation, input level,
                   input mean_level, input deviation, output ready);
endinterface

interface loq_rsp_if
   import loq_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [1:0]          verdict;
   logic                outlier_flag;
   logic [COUNT_W-1:0]  outlier_count;
   logic [LEVEL_W-1:0]  bad_value;
   logic [LEVEL_W-1:0]  good_value;

   modport source (output valid, output verdict, output outlier_flag,
                   output outlier_count, output bad_value, output good_value,
                   input ready);
   modport sink   (input valid, input verdict, input outlier_flag,
                   input outlier_count, input bad_value, input good_value,
                   output ready);
endinterface

[sv/loq_eval.sv]
// ----------------------------------------------------------------------------
// loq_eval
// one-pass qualification of a report against the outlier state
// ----------------------------------------------------------------------------
module loq_eval
   import loq_pkg::*;
#(
   parameter int COUNT_MAX = COUNT_MAX_DEFAULT
) (
   input  req_item_type item,
   input  state_type    state,
   input  cfg_type      cfg,
   output state_type    state_next,
   output rsp_item_type result
);

   localparam int CountSatInt = (COUNT_MAX < 255) ? COUNT_MAX : 255;
   localparam logic [COUNT_W-1:0] CountSat = COUNT_W'(CountSatInt);

   logic                outlier;
   logic [COUNT_W-1:0]  count_inc;
   logic [LEVEL_W-1:0]  bad_eff;
   logic [LEVEL_W-1:0]  good_eff;
   logic [Q_W-1:0]      bad_center;
   logic [Q_W-1:0]      good_center;
   logic [Q_W:0]        mean_plus_tol;
   logic                in_bad_win;
   logic                in_good_win;

   assign outlier   = item.deviation > cfg.deviation_limit;
   assign count_inc = (state.count < CountSat) ? state.count + 1'b1 : state.count;

   // refresh of good value happens only with an empty count
   assign bad_eff  = (state.count == '0) ? '0 : state.bad;
   assign good_eff = (state.count == '0) ? item.mean_level[Q_W-1:FRAC_W] : state.good;

   assign bad_center    = {bad_eff, {FRAC_W{1'b0}}};
   assign good_center   = {good_eff, {FRAC_W{1'b0}}};
   assign mean_plus_tol = {1'b0, item.mean_level} + {1'b0, cfg.mean_tolerance};

   // c - tol <= m <= c + tol, rewritten without any wrap
   assign in_bad_win  = ({1'b0, item.mean_level} <= {1'b0, bad_center} + {1'b0, cfg.mean_tolerance})
                        && (mean_plus_tol >= {1'b0, bad_center});
   assign in_good_win = ({1'b0, item.mean_level} <= {1'b0, good_center} + {1'b0, cfg.mean_tolerance})
                        && (mean_plus_tol >= {1'b0, good_center});

   always_comb begin
      state_next          = state;
      result.verdict      = VERDICT_OK;
      result.outlier_flag = 1'b0;
      unique case (item.operation)
         OP_CLEAR: begin
            state_next = '0;
         end
         OP_EVALUATE: begin
            if (outlier) begin
               result.outlier_flag = 1'b1;
               state_next.count    = count_inc;
               if (count_inc == COUNT_W'(1)) begin
                  state_next.bad = item.level;
               end
               if (count_inc >= cfg.alarm_count) begin
                  result.verdict = VERDICT_ALARM;
               end
            end else begin
               state_next.bad  = bad_eff;
               state_next.good = good_eff;
               if (in_bad_win) begin
                  result.verdict = VERDICT_HEAD_RESET;
               end else if (in_good_win) begin
                  state_next.count = '0;
               end
            end
         end
         default: begin
            state_next = state;
         end
      endcase
      result.outlier_count = state_next.count;
      result.bad_value     = state_next.bad;
      result.good_value    = state_next.good;
   end

endmodule

[sv/level_outlier_qualifier_top.sv]
// ----------------------------------------------------------------------------
// level_outlier_qualifier_top
// qualifies sensor level reports, tracks outliers, raises alarm / head reset
// ----------------------------------------------------------------------------
//  port   | dir | handshake       | carries
//  req    | in  | valid / ready   | operation, level, mean_level, deviation
//  rsp    | out | valid / ready   | verdict, outlier_flag, outlier_count,
//         |     |                 | bad_value, good_value
//  csr_*  | in  | csr_wr_en only  | csr_index, csr_wr_data
//
//  one item per cycle sustained while rsp is ready; an accepted item goes into the
//  input register, then through the qualify logic into the result register
//  state is updated as an item moves into the result register, so the next
//  item in the input register already sees it
//  a stalled rsp holds the result; the input register still fills, then req
//  ready drops until the result register frees up
//  reset (synchronous, active high) empties both stages, zeroes outlier
//  state and loads the register defaults
// ----------------------------------------------------------------------------
module level_outlier_qualifier_top
   import loq_pkg::*;
#(
   parameter int COUNT_MAX = COUNT_MAX_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   loq_req_if.sink               req,
   loq_rsp_if.source             rsp,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int CountSatInt = (COUNT_MAX < 255) ? COUNT_MAX : 255;
   localparam logic [COUNT_W-1:0] CountSat = COUNT_W'(CountSatInt);

   // input stage
   logic          in_vld_ff;
   logic          in_vld_in;
   req_item_type  in_ff;
   req_item_type  req_item;

   // result stage
   logic          rsp_vld_ff;
   logic          rsp_vld_in;
   rsp_item_type  rsp_ff;
   rsp_item_type  eval_result;

   // outlier state and configuration
   state_type     state_ff;
   state_type     state_in;
   state_type     eval_state;
   cfg_type       cfg_ff;
   cfg_type       cfg_in;

   logic          advance;
   logic          req_take;

   // move an item forward when the result register is empty or being drained
   assign advance  = in_vld_ff && (!rsp_vld_ff || rsp.ready);
   assign req.ready = !in_vld_ff || advance;
   assign req_take = req.valid && req.ready;

   assign req_item.operation  = op_type'(req.operation);
   assign req_item.level      = req.level;
   assign req_item.mean_level = req.mean_level;
   assign req_item.deviation  = req.deviation;

   loq_eval #(
      .COUNT_MAX (COUNT_MAX)
   ) u_eval (
      .item       (in_ff),
      .state      (state_ff),
      .cfg        (cfg_ff),
      .state_next (eval_state),
      .result     (eval_result)
   );

   always_comb begin
      in_vld_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
      rsp_vld_in = advance ? 1'b1 : ((rsp_vld_ff && rsp.ready) ? 1'b0 : rsp_vld_ff);
      state_in   = advance ? eval_state : state_ff;
   end

   // register writes; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEVIATION_LIMIT: cfg_in.deviation_limit = csr_wr_data[Q_W-1:0];
            CSR_MEAN_TOLERANCE:  cfg_in.mean_tolerance  = csr_wr_data[Q_W-1:0];
            CSR_ALARM_COUNT:     cfg_in.alarm_count     = csr_wr_data[COUNT_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff              <= 1'b0;
         rsp_vld_ff             <= 1'b0;
         state_ff               <= '0;
         cfg_ff.deviation_limit <= DEVIATION_LIMIT_RST;
         cfg_ff.mean_tolerance  <= MEAN_TOLERANCE_RST;
         cfg_ff.alarm_count     <= ALARM_COUNT_RST;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         state_ff   <= state_in;
         cfg_ff     <= cfg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_item;
      end
      if (advance) begin
         rsp_ff <= eval_result;
      end
   end

   assign rsp.valid         = rsp_vld_ff;
   assign rsp.verdict       = rsp_ff.verdict;
   assign rsp.outlier_flag  = rsp_ff.outlier_flag;
   assign rsp.outlier_count = rsp_ff.outlier_count;
   assign rsp.bad_value     = rsp_ff.bad_value;
   assign rsp.good_value    = rsp_ff.good_value;

   // count never passes its saturation point
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      state_ff.count <= CountSat)
      else $error("outlier count above saturation");

   // a clear item leaves all outlier state zero
   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      advance && (in_ff.operation == OP_CLEAR) |=>
         (state_ff.count == '0) && (state_ff.bad == '0) && (state_ff.good == '0))
      else $error("clear did not zero outlier state");

   // an outlier result never asks for a head reset and always has a count
   a_outlier_result: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.outlier_flag |->
         (rsp_ff.verdict != VERDICT_HEAD_RESET) && (rsp_ff.outlier_count != '0))
      else $error("inconsistent outlier result");

   // a waiting item is not dropped while the result side is stalled
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff && $stable(in_ff))
      else $error("input register lost an item");

   // result register reports exactly what the state holds after its item
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_ff.outlier_count == state_ff.count)
         && (rsp_ff.bad_value == state_ff.bad) && (rsp_ff.good_value == state_ff.good))
      else $error("result does not match updated state");

endmodule

[test/level_outlier_qualifier_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// level_outlier_qualifier_top_tb
// drives sensor level reports into the qualifier, predicts each verdict item
// by hand or with an independent model of the outlier state and compares each
// field in order; walks several register settings with random idling
// ----------------------------------------------------------------------------
module level_outlier_qualifier_top_tb;
   import loq_pkg::*;

   // saturation point of the outlier count for the default parameter
   localparam int COUNT_CAP    = (COUNT_MAX_DEFAULT < 255) ? COUNT_MAX_DEFAULT : 255;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;     // drain margin past the two-stage pipeline
   localparam int HOLD_CYCLES  = 48;    // long result back-pressure
   localparam int IDLE_PCT     = 22;
   localparam int N_DIRECTED   = 21;
   localparam logic [Q_W-1:0] Q_MAX = '1;

   typedef struct {
      req_item_type report;
      bit           typed;    // expected result written by hand
      rsp_item_type want;
   } directed_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   // pacing controls shared between the sender and the receiver
   logic steady;      // no idling on either side
   logic hold_go;     // starts the long result hold-off
   logic stall_rsp;   // result ready held low

   int mismatches = 0;

   // model of the block: outlier state and register settings
   state_type    tracked;
   cfg_type      settings;
   rsp_item_type predicted_verdicts [$];

   loq_req_if req ();
   loq_rsp_if rsp ();

   level_outlier_qualifier_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // directed reports, register defaults in force
   // the first rows are simple enough to write down the result by hand
   directed_row_type directed_rows [N_DIRECTED] = '{
      // zero report at reset: mean sits inside the window around a zero bad value
      '{'{OP_EVALUATE, 16'h0000, 20'h00000, 20'h00000}, 1'b1,
        '{VERDICT_HEAD_RESET, 1'b0, 8'd0, 16'h0000, 16'h0000}},
      // deviation one above the limit: first outlier captures the level
      '{'{OP_EVALUATE, 16'hffff, 20'h00000, 20'h000a1}, 1'b1,
        '{VERDICT_OK, 1'b1, 8'd1, 16'hffff, 16'h0000}},
      // largest deviation: count moves on, bad value kept
      '{'{OP_EVALUATE, 16'h1234, 20'hfffff, 20'hfffff}, 1'b1,
        '{VERDICT_OK, 1'b1, 8'd2, 16'hffff, 16'h0000}},
      // deviation equal to the limit is not an outlier; largest mean matches bad value
      '{'{OP_EVALUATE, 16'h0000, 20'hfffff, 20'h000a0}, 1'b1,
        '{VERDICT_HEAD_RESET, 1'b0, 8'd2, 16'hffff, 16'h0000}},
      // mean back at the good value clears the count
      '{'{OP_EVALUATE, 16'hffff, 20'h00000, 20'h00000}, 1'b1,
        '{VERDICT_OK, 1'b0, 8'd0, 16'hffff, 16'h0000}},
      // zero count refreshes the good value and drops the bad value
      '{'{OP_EVALUATE, 16'h0000, 20'h12345, 20'h00000}, 1'b1,
        '{VERDICT_OK, 1'b0, 8'd0, 16'h0000, 16'h1234}},
      // clear with every input bit set
      '{'{OP_CLEAR, 16'hffff, 20'hfffff, 20'hfffff}, 1'b1,
        '{VERDICT_OK, 1'b0, 8'd0, 16'h0000, 16'h0000}},
      // run of outliers up to and past the alarm count
      '{'{OP_EVALUATE, 16'habcd, 20'h00000, 20'hfffff}, 1'b0, '0},
      '{'{OP_EVALUATE, 16'h0000, 20'hfffff, 20'h000a1}, 1'b0, '0},
      '{'{OP_EVALUATE, 16'hffff, 20'h55555, 20'haaaaa}, 1'b0, '0},
      '{'{OP_EVALUATE, 16'h5a5a, 20'haaaaa, 20'h55555}, 1'b0, '0},
      '{'{OP_EVALUATE, 16'h0000, 20'h00000, 20'hfffff}, 1'b0, '0},
      '{'{OP_EVALUATE, 16'hffff, 20'hfffff, 20'hfffff}, 1'b0, '0},
      // both edges of the window around the bad value, inside and just outside
      '{'{OP_EVALUATE, 16'h0000, 20'habe10, 20'h00000}, 1'b0, '0},
      '{'{OP_EVALUATE, 16'h0000, 20'habe11, 20'h000a0}, 1'b0, '0},
      '{'{OP_EVALUATE, 16'h0000, 20'habb90, 20'h00000}, 1'b0, '0},
      '{'{OP_EVALUATE, 16'h0000, 20'habb8f, 20'h00000}, 1'b0, '0},
      // upper edge of the window around a zero good value
      '{'{OP_EVALUATE, 16'h0000, 20'h00140, 20'h00000}, 1'b0, '0},
      '{'{OP_EVALUATE, 16'h0000, 20'h00141, 20'h00000}, 1'b0, '0},
      '{'{OP_EVALUATE, 16'h0000, 20'h00000, 20'h00000}, 1'b0, '0},
      '{'{OP_CLEAR, 16'h0000, 20'h00000, 20'h00000}, 1'b0, '0}
   };

   // exact window test, no wrap at either end
   function automatic bit near_center(logic [Q_W-1:0] mean, logic [LEVEL_W-1:0] center,
                                      logic [Q_W-1:0] tol);
      longint c;
      longint m;
      longint t;
      c = longint'(center) * 16;
      m = longint'(mean);
      t = longint'(tol);
      return (m <= c + t) && (m >= c - t);
   endfunction

   // next verdict item of the block; advances the tracked state
   function automatic rsp_item_type qualify_report(req_item_type r);
      rsp_item_type res;
      res = '0;
      res.verdict = VERDICT_OK;
      if (r.operation == OP_CLEAR) begin
         tracked = '0;
      end else if (r.deviation > settings.deviation_limit) begin
         res.outlier_flag = 1'b1;
         if (tracked.count < COUNT_CAP) tracked.count = tracked.count + 1'b1;
         if (tracked.count == 1) tracked.bad = r.level;
         if (tracked.count >= settings.alarm_count) res.verdict = VERDICT_ALARM;
      end else begin
         // trusted report with no outliers pending: take its mean as the good value
         if (tracked.count == 0) begin
            tracked.good = r.mean_level[Q_W-1:FRAC_W];
            tracked.bad  = '0;
         end
         if (near_center(r.mean_level, tracked.bad, settings.mean_tolerance))
            res.verdict = VERDICT_HEAD_RESET;
         else if (near_center(r.mean_level, tracked.good, settings.mean_tolerance))
            tracked.count = '0;
      end
      res.outlier_count = tracked.count;
      res.bad_value     = tracked.bad;
      res.good_value    = tracked.good;
      return res;
   endfunction

   // a mean at, just past or inside the window around a stored value
   function automatic logic [Q_W-1:0] mean_near(logic [LEVEL_W-1:0] center);
      longint c;
      longint t;
      longint m;
      c = longint'(center) * 16;
      t = longint'(settings.mean_tolerance);
      case ($urandom_range(0, 3))
         0: m = c + t;
         1: m = c - t;
         2: m = $urandom_range(0, 1) ? c + t + 1 : c - t - 1;
         default: m = c - t + longint'($urandom_range(0, 2 * t));
      endcase
      if (m < 0) m = 0;
      if (m > longint'(Q_MAX)) m = longint'(Q_MAX);
      return Q_W'(m);
   endfunction

   // random report, mostly shaped to hit the outlier and window paths
   function automatic req_item_type make_report(int outlier_pct);
      req_item_type r;
      int           pick;
      logic [Q_W-1:0] lim;
      lim = settings.deviation_limit;
      r.operation  = OP_EVALUATE;
      r.mean_level = Q_W'($urandom);
      case ($urandom_range(0, 9))
         0: r.level = '0;
         1: r.level = '1;
         default: r.level = LEVEL_W'($urandom);
      endcase
      // trusted deviation by default, often exactly at the limit
      r.deviation = ($urandom_range(0, 3) == 0) ? lim : Q_W'($urandom_range(0, lim));
      pick = $urandom_range(0, 99);
      if (pick < outlier_pct) begin
         if (lim == Q_MAX)
            r.deviation = Q_W'($urandom);
         else if ($urandom_range(0, 3) == 0)
            r.deviation = lim + 1'b1;
         else
            r.deviation = Q_W'($urandom_range(lim + 1, Q_MAX));
      end else if (pick < outlier_pct + 20) begin
         r.mean_level = mean_near(tracked.bad);
      end else if (pick < outlier_pct + 40) begin
         r.mean_level = mean_near(tracked.good);
      end else if (pick >= 95) begin
         // noise: every field random, clear included
         r.operation = op_type'($urandom_range(0, 1));
         r.deviation = Q_W'($urandom);
      end else if (pick >= 90) begin
         r.operation = OP_CLEAR;
      end
      return r;
   endfunction

   function automatic void compare_field(string name, logic [LEVEL_W-1:0] want,
                                         logic [LEVEL_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   task automatic check_result(rsp_item_type got);
      rsp_item_type want;
      if (predicted_verdicts.size() == 0) begin
         $display("%0t: unexpected result item, expected none, actual %h", $time, got);
         mismatches++;
         return;
      end
      want = predicted_verdicts.pop_front();
      compare_field("verdict", LEVEL_W'(want.verdict), LEVEL_W'(got.verdict));
      compare_field("outlier_flag", LEVEL_W'(want.outlier_flag), LEVEL_W'(got.outlier_flag));
      compare_field("outlier_count", LEVEL_W'(want.outlier_count),
                    LEVEL_W'(got.outlier_count));
      compare_field("bad_value", want.bad_value, got.bad_value);
      compare_field("good_value", want.good_value, got.good_value);
   endtask

   // offer one item, idling first at random; called just after the clock rises
   task automatic offer_report(directed_row_type row);
      rsp_item_type res;
      if (!steady) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req.valid      <= 1'b1;
      req.operation  <= row.report.operation;
      req.level      <= row.report.level;
      req.mean_level <= row.report.mean_level;
      req.deviation  <= row.report.deviation;
      do @(posedge clock); while (!req.ready);
      // accepted at this edge: state moves on in acceptance order
      res = qualify_report(row.report);
      predicted_verdicts.push_back(row.typed ? row.want : res);
   endtask

   task automatic offer_random(int outlier_pct);
      directed_row_type row;
      row.report = make_report(outlier_pct);
      row.typed  = 1'b0;
      row.want   = '0;
      offer_report(row);
   endtask

   // sender quiet until every predicted item has come back, then a short drain
   task automatic settle();
      req.valid <= 1'b0;
      while (predicted_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // back-to-back register writes while the block is idle
   task automatic write_settings(cfg_type s);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_DEVIATION_LIMIT;
      csr_wr_data <= CSR_DATA_W'(s.deviation_limit);
      @(posedge clock);
      csr_index   <= CSR_MEAN_TOLERANCE;
      csr_wr_data <= CSR_DATA_W'(s.mean_tolerance);
      @(posedge clock);
      csr_index   <= CSR_ALARM_COUNT;
      csr_wr_data <= CSR_DATA_W'(s.alarm_count);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      settings = s;
   endtask

   task automatic run_phase(cfg_type s, int n_items, int outlier_pct);
      settle();
      write_settings(s);
      repeat (n_items) offer_random(outlier_pct);
   endtask

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("level_outlier_qualifier_top_tb: done, errors");
      $finish;
   end

   // long result hold-off, counted here while the sender keeps offering
   initial begin : result_hold
      stall_rsp <= 1'b0;
      wait (hold_go === 1'b1);
      @(posedge clock);
      stall_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      stall_rsp <= 1'b0;
   end

   // result side: sample at the edge, drive ready, compare a moment later so
   // the prediction pushed at the same edge is already in the queue
   initial begin : result_sink
      rsp_item_type got;
      bit           took;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         took = !reset && rsp.valid && rsp.ready;
         got.verdict       = verdict_type'(rsp.verdict);
         got.outlier_flag  = rsp.outlier_flag;
         got.outlier_count = rsp.outlier_count;
         got.bad_value     = rsp.bad_value;
         got.good_value    = rsp.good_value;
         if (stall_rsp)
            rsp.ready <= 1'b0;
         else if (steady)
            rsp.ready <= 1'b1;
         else
            rsp.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
         if (took) begin
            #1;
            check_result(got);
         end
      end
   end

   // stimulus
   initial begin : report_source
      cfg_type s;
      // every input known from the start
      reset          <= 1'b1;
      steady         <= 1'b0;
      hold_go        <= 1'b0;
      csr_wr_en      <= 1'b0;
      csr_index      <= CSR_DEVIATION_LIMIT;
      csr_wr_data    <= '0;
      req.valid      <= 1'b0;
      req.operation  <= OP_EVALUATE;
      req.level      <= '0;
      req.mean_level <= '0;
      req.deviation  <= '0;
      tracked  = '0;
      settings = '{DEVIATION_LIMIT_RST, MEAN_TOLERANCE_RST, ALARM_COUNT_RST};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed reports on the reset defaults
      foreach (directed_rows[i]) offer_report(directed_rows[i]);

      // random mid settings; flood the block while results are held off
      settle();
      s.deviation_limit = Q_W'($urandom_range(16, 4000));
      s.mean_tolerance  = Q_W'($urandom_range(0, 2000));
      s.alarm_count     = COUNT_W'($urandom_range(2, 8));
      write_settings(s);
      steady  <= 1'b1;
      hold_go <= 1'b1;
      repeat (60) offer_random(30);
      steady  <= 1'b0;
      // pause until every outstanding item has come back
      req.valid <= 1'b0;
      while (predicted_verdicts.size() != 0) @(posedge clock);
      repeat (60) offer_random(30);

      // low extremes: any nonzero deviation is an outlier, every outlier an alarm
      run_phase('{20'd0, 20'd0, 8'd1}, 120, 30);
      // high extremes: no outliers possible, very wide windows
      run_phase('{Q_MAX, Q_MAX, 8'd255}, 120, 30);
      // zero alarm count: every outlier alarms
      run_phase('{20'd800, 20'd48, 8'd0}, 120, 30);
      // long unbroken outlier run to saturate the count, then mixed reports
      run_phase('{20'd100, 20'd320, 8'd255}, 265, 100);
      repeat (80) offer_random(30);
      // back to the defaults with no idling on either side
      settle();
      steady <= 1'b1;
      run_phase('{DEVIATION_LIMIT_RST, MEAN_TOLERANCE_RST, ALARM_COUNT_RST}, 120, 30);

      settle();
      if (mismatches == 0)
         $display("level_outlier_qualifier_top_tb: done, clean");
      else
         $display("level_outlier_qualifier_top_tb: done, errors");
      $finish;
   end

endmodule
